### rtl/spitft_pkg.sv
package spitft_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_value;
      logic       chip_select_high;
   } req_payload_type;

   typedef struct packed {
      logic        fb_write;
      logic [16:0] fb_address;
      logic [23:0] fb_color;
      logic        panel_lit;
      logic [31:0] pixels_written;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [15:0] write_column;
      logic [15:0] write_page;
      logic [7:0]  access_control;
      logic        inverted;
   } pix_ctrl_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] address;
      logic [23:0] color;
   } pix_result_type;

   localparam logic [7:0] CMD_SWRESET = 8'h01;
   localparam logic [7:0] CMD_INVOFF  = 8'h20;
   localparam logic [7:0] CMD_INVON   = 8'h21;
   localparam logic [7:0] CMD_DISPOFF = 8'h28;
   localparam logic [7:0] CMD_DISPON  = 8'h29;
   localparam logic [7:0] CMD_CASET   = 8'h2A;
   localparam logic [7:0] CMD_PASET   = 8'h2B;
   localparam logic [7:0] CMD_RAMWR   = 8'h2C;
   localparam logic [7:0] CMD_RAMWRC  = 8'h3C;
   localparam logic [7:0] CMD_MADCTL  = 8'h36;

   localparam int unsigned AC_ROWFLIP_BIT = 7;
   localparam int unsigned AC_COLFLIP_BIT = 6;
   localparam int unsigned AC_SWAP_BIT    = 5;
   localparam int unsigned AC_BGR_BIT     = 3;

   localparam logic [23:0] COLOR_MASK = 24'hFFFFFF;

   localparam logic [7:0] CSR_DC_WIRED  = 8'd0;
   localparam logic [7:0] CSR_CS_IN_USE = 8'd1;

   localparam logic [2:0] PARAM_COUNT_MAX = 3'd7;
   localparam logic [2:0] PARAM_LAST_IDX  = 3'd3;

endpackage

### rtl/spitft_pixel_map.sv
module spitft_pixel_map #(
   parameter int PANEL_WIDTH  = 240,
   parameter int PANEL_HEIGHT = 320
) (
   input  spitft_pkg::pix_ctrl_type   ctrl,
   output spitft_pkg::pix_result_type result
);

   localparam logic signed [17:0] WidthLast  = 18'(PANEL_WIDTH - 1);
   localparam logic signed [17:0] HeightLast = 18'(PANEL_HEIGHT - 1);
   localparam logic signed [17:0] WidthS     = 18'(PANEL_WIDTH);
   localparam logic signed [17:0] HeightS    = 18'(PANEL_HEIGHT);
   localparam logic [16:0]        WidthU     = 17'(PANEL_WIDTH);

   logic [4:0]         red;
   logic [5:0]         green;
   logic [4:0]         blue;
   logic [23:0]        rgb;
   logic signed [17:0] mc;
   logic signed [17:0] mr;
   logic signed [17:0] x;
   logic signed [17:0] y;
   logic [33:0]        row_base;

   always_comb begin
      red   = ctrl.pixel[15:11];
      green = ctrl.pixel[10:5];
      blue  = ctrl.pixel[4:0];
      if (!ctrl.access_control[spitft_pkg::AC_BGR_BIT]) begin
         red  = ctrl.pixel[4:0];
         blue = ctrl.pixel[15:11];
      end
      rgb = {red, red[4:2], green, green[5:4], blue, blue[4:2]};
      if (ctrl.inverted) begin
         rgb = rgb ^ spitft_pkg::COLOR_MASK;
      end

      mc = $signed({2'b00, ctrl.write_column});
      mr = $signed({2'b00, ctrl.write_page});
      if (ctrl.access_control[spitft_pkg::AC_SWAP_BIT]) begin
         mc = $signed({2'b00, ctrl.write_page});
         mr = $signed({2'b00, ctrl.write_column});
      end
      if (ctrl.access_control[spitft_pkg::AC_COLFLIP_BIT]) begin
         mc = WidthLast - mc;
      end
      if (ctrl.access_control[spitft_pkg::AC_ROWFLIP_BIT]) begin
         mr = HeightLast - mr;
      end
      x = WidthLast - mc;
      y = mr;

      row_base       = y[16:0] * WidthU;
      result.hit     = (x >= 18'sd0) && (x < WidthS) && (y >= 18'sd0) && (y < HeightS);
      result.address = row_base[16:0] + x[16:0];
      result.color   = rgb;
   end

endmodule

### rtl/spi_tft_display_command_decoder_core.sv
// SPI display command decoder.
// Input channel req_*: one SPI byte per beat, flagged as command or data, with
// the chip select level. Output channel rsp_*: exactly one beat per input beat,
// in order, carrying a frame memory write (fb_write, address, 24-bit color)
// when the byte completed an on-panel RGB565 pixel, plus the display-on flag
// and the running pixel count.
// Configuration channel csr_*: index 0 sets dc_wired, index 1 sets cs_in_use;
// bit 0 of the write data is taken. csr_ready is always high.
// An accepted input beat is held in an input register; its result is decoded
// from there and lands in the output register, which drives rsp_valid.
// Throughput is one byte per cycle while the output is not stalled, set by
// the single decode pass (one row multiply for the address) between the two
// registers.
// Reset clears all decoder state, both configuration bits and both valid
// flags. When rsp_ready is low the result holds in the output register; the
// input register still takes one more beat, then req_ready drops until the
// output drains.
module spi_tft_display_command_decoder_core #(
   parameter int PANEL_WIDTH  = 240,
   parameter int PANEL_HEIGHT = 320
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spitft_pkg::req_payload_type   req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spitft_pkg::rsp_payload_type   rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [7:0]                    csr_index,
   input  logic [7:0]                    csr_wdata
);

   localparam logic [15:0] ColumnEndReset = 16'(PANEL_WIDTH - 1);
   localparam logic [15:0] PageLastReset  = 16'(PANEL_HEIGHT - 1);

   logic                         in_valid_ff;
   spitft_pkg::req_payload_type  in_payload_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   spitft_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic                         advance;

   logic        dc_wired_ff, dc_wired_in;
   logic        cs_in_use_ff, cs_in_use_in;
   logic [7:0]  current_command_ff, current_command_in;
   logic [2:0]  param_count_ff, param_count_in;
   logic [7:0]  param_bytes_ff [3];
   logic [7:0]  param_bytes_in [3];
   logic [15:0] column_start_ff, column_start_in;
   logic [15:0] column_end_ff, column_end_in;
   logic [15:0] page_first_ff, page_first_in;
   logic [15:0] page_last_ff, page_last_in;
   logic [15:0] write_column_ff, write_column_in;
   logic [15:0] write_page_ff, write_page_in;
   logic [7:0]  access_control_ff, access_control_in;
   logic        high_byte_pending_ff, high_byte_pending_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic        panel_lit_ff, panel_lit_in;
   logic        inverted_flag_ff, inverted_flag_in;
   logic [31:0] pixel_counter_ff, pixel_counter_in;

   logic                        active;
   logic                        pixel_done;
   spitft_pkg::pix_ctrl_type    pix_ctrl;
   spitft_pkg::pix_result_type  pix_result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready = 1'b1;

   assign pix_ctrl.pixel          = {high_byte_ff, in_payload_ff.byte_value};
   assign pix_ctrl.write_column   = write_column_ff;
   assign pix_ctrl.write_page     = write_page_ff;
   assign pix_ctrl.access_control = access_control_ff;
   assign pix_ctrl.inverted       = inverted_flag_ff;

   spitft_pixel_map #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_pixel_map (
      .ctrl  (pix_ctrl),
      .result(pix_result)
   );

   always_comb begin
      dc_wired_in  = dc_wired_ff;
      cs_in_use_in = cs_in_use_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spitft_pkg::CSR_DC_WIRED:  dc_wired_in  = csr_wdata[0];
            spitft_pkg::CSR_CS_IN_USE: cs_in_use_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      current_command_in   = current_command_ff;
      param_count_in       = param_count_ff;
      param_bytes_in       = param_bytes_ff;
      column_start_in      = column_start_ff;
      column_end_in        = column_end_ff;
      page_first_in        = page_first_ff;
      page_last_in         = page_last_ff;
      write_column_in      = write_column_ff;
      write_page_in        = write_page_ff;
      access_control_in    = access_control_ff;
      high_byte_pending_in = high_byte_pending_ff;
      high_byte_in         = high_byte_ff;
      panel_lit_in         = panel_lit_ff;
      inverted_flag_in     = inverted_flag_ff;
      pixel_counter_in     = pixel_counter_ff;
      pixel_done           = 1'b0;

      active = dc_wired_ff && !(cs_in_use_ff && in_payload_ff.chip_select_high);

      if (advance && active) begin
         if (!in_payload_ff.command) begin
            current_command_in   = in_payload_ff.byte_value;
            param_count_in       = '0;
            high_byte_pending_in = 1'b0;
            unique case (in_payload_ff.byte_value)
               spitft_pkg::CMD_SWRESET: begin
                  current_command_in = '0;
                  column_start_in    = '0;
                  column_end_in      = ColumnEndReset;
                  page_first_in      = '0;
                  page_last_in       = PageLastReset;
                  write_column_in    = '0;
                  write_page_in      = '0;
                  access_control_in  = '0;
                  panel_lit_in       = 1'b0;
                  inverted_flag_in   = 1'b0;
               end
               spitft_pkg::CMD_INVOFF:  inverted_flag_in = 1'b0;
               spitft_pkg::CMD_INVON:   inverted_flag_in = 1'b1;
               spitft_pkg::CMD_DISPOFF: panel_lit_in     = 1'b0;
               spitft_pkg::CMD_DISPON:  panel_lit_in     = 1'b1;
               spitft_pkg::CMD_RAMWR: begin
                  write_column_in = column_start_ff;
                  write_page_in   = page_first_ff;
               end
               default: ;
            endcase
         end else begin
            unique case (current_command_ff) inside
               spitft_pkg::CMD_CASET, spitft_pkg::CMD_PASET: begin
                  if (param_count_ff < spitft_pkg::PARAM_LAST_IDX) begin
                     param_bytes_in[param_count_ff[1:0]] = in_payload_ff.byte_value;
                  end
                  if (param_count_ff == spitft_pkg::PARAM_LAST_IDX) begin
                     if (current_command_ff == spitft_pkg::CMD_CASET) begin
                        column_start_in = {param_bytes_ff[0], param_bytes_ff[1]};
                        column_end_in   = {param_bytes_ff[2], in_payload_ff.byte_value};
                     end else begin
                        page_first_in = {param_bytes_ff[0], param_bytes_ff[1]};
                        page_last_in  = {param_bytes_ff[2], in_payload_ff.byte_value};
                     end
                  end
                  if (param_count_ff != spitft_pkg::PARAM_COUNT_MAX) begin
                     param_count_in = param_count_ff + 3'd1;
                  end
               end
               spitft_pkg::CMD_MADCTL: begin
                  if (param_count_ff == '0) begin
                     access_control_in = in_payload_ff.byte_value;
                  end
                  if (param_count_ff != spitft_pkg::PARAM_COUNT_MAX) begin
                     param_count_in = param_count_ff + 3'd1;
                  end
               end
               spitft_pkg::CMD_RAMWR, spitft_pkg::CMD_RAMWRC: begin
                  if (!high_byte_pending_ff) begin
                     high_byte_in         = in_payload_ff.byte_value;
                     high_byte_pending_in = 1'b1;
                  end else begin
                     high_byte_pending_in = 1'b0;
                     pixel_done           = 1'b1;
                     pixel_counter_in     = pixel_counter_ff + 32'd1;
                     if (write_column_ff < column_end_ff) begin
                        write_column_in = write_column_ff + 16'd1;
                     end else begin
                        write_column_in = column_start_ff;
                        write_page_in   = (write_page_ff < page_last_ff) ?
                                          write_page_ff + 16'd1 : page_first_ff;
                     end
                  end
               end
               default: begin
                  if (param_count_ff != spitft_pkg::PARAM_COUNT_MAX) begin
                     param_count_in = param_count_ff + 3'd1;
                  end
               end
            endcase
         end
      end

      rsp_payload_in.fb_write       = pixel_done && pix_result.hit;
      rsp_payload_in.fb_address     = rsp_payload_in.fb_write ? pix_result.address : '0;
      rsp_payload_in.fb_color       = rsp_payload_in.fb_write ? pix_result.color : '0;
      rsp_payload_in.panel_lit      = panel_lit_in;
      rsp_payload_in.pixels_written = pixel_counter_in;

      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_payload_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         dc_wired_ff          <= 1'b0;
         cs_in_use_ff         <= 1'b0;
         current_command_ff   <= '0;
         param_count_ff       <= '0;
         param_bytes_ff       <= '{default: '0};
         column_start_ff      <= '0;
         column_end_ff        <= ColumnEndReset;
         page_first_ff        <= '0;
         page_last_ff         <= PageLastReset;
         write_column_ff      <= '0;
         write_page_ff        <= '0;
         access_control_ff    <= '0;
         high_byte_pending_ff <= 1'b0;
         high_byte_ff         <= '0;
         panel_lit_ff         <= 1'b0;
         inverted_flag_ff     <= 1'b0;
         pixel_counter_ff     <= '0;
      end else begin
         in_valid_ff          <= (req_valid && req_ready) || (in_valid_ff && !advance);
         rsp_valid_ff         <= rsp_valid_in;
         dc_wired_ff          <= dc_wired_in;
         cs_in_use_ff         <= cs_in_use_in;
         current_command_ff   <= current_command_in;
         param_count_ff       <= param_count_in;
         param_bytes_ff       <= param_bytes_in;
         column_start_ff      <= column_start_in;
         column_end_ff        <= column_end_in;
         page_first_ff        <= page_first_in;
         page_last_ff         <= page_last_in;
         write_column_ff      <= write_column_in;
         write_page_ff        <= write_page_in;
         access_control_ff    <= access_control_in;
         high_byte_pending_ff <= high_byte_pending_in;
         high_byte_ff         <= high_byte_in;
         panel_lit_ff         <= panel_lit_in;
         inverted_flag_ff     <= inverted_flag_in;
         pixel_counter_ff     <= pixel_counter_in;
      end
   end

endmodule

### rtl/spitft_checker.sv
module spitft_checker #(
   parameter int PANEL_WIDTH  = 240,
   parameter int PANEL_HEIGHT = 320
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input spitft_pkg::rsp_payload_type rsp_payload
);

   localparam logic [16:0] AddressLimit = 17'(PANEL_WIDTH * PANEL_HEIGHT - 1);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.fb_write |->
         rsp_payload.fb_address == '0 && rsp_payload.fb_color == '0)
      else $error("address or color set without a write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fb_write |-> rsp_payload.fb_address <= AddressLimit)
      else $error("write address off the panel");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind spi_tft_display_command_decoder_core spitft_checker #(
   .PANEL_WIDTH (PANEL_WIDTH),
   .PANEL_HEIGHT(PANEL_HEIGHT)
) u_spitft_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);
